// ===== hw/rtl/rms_mtr_pkg.sv =====
`default_nettype none

package rms_mtr_pkg;

  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned TAG_W     = 8;
  localparam int unsigned RMS_W     = 24;
  localparam int unsigned MAX_BLOCK = 4096;

  // A square needs 2*SAMPLE_W-1 bits, and the sum adds log2(MAX_BLOCK) bits to that.
  localparam int unsigned SQ_W    = 2 * SAMPLE_W - 1;
  localparam int unsigned SUM_W   = SQ_W + $clog2(MAX_BLOCK);
  // The quotient keeps the full sum width, since a lowered length can end a long block
  // with a small divisor.
  localparam int unsigned WORK_W  = SUM_W + 1;
  localparam int unsigned ROOT_W  = WORK_W / 2;
  localparam int unsigned SREM_W  = ROOT_W + 2;

  localparam int unsigned SQ_STEPS   = SAMPLE_W;
  localparam int unsigned DIV_STEPS  = SUM_W;
  localparam int unsigned ROOT_STEPS = ROOT_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_W      = LEN_W;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_TAG     = 1'd1;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_BLOCK);
  localparam logic [TAG_W-1:0] TAG_RESET = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CHECK,
    ST_DIVIDE,
    ST_ROOT,
    ST_DONE
  } rms_state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/block_rms_meter_unit.sv =====
`default_nettype none
// RMS level meter over blocks of audio samples.
// Input stream: one signed Q1.23 sample per beat on s_axis_tdata. Output stream: one beat
// per finished block on m_axis_tdata, carrying the floored root of the mean square in
// unsigned Q1.23 and the configured port tag. Registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i: block length (index 0, zero acts as one, capped at 4096) and
// port tag (index 1). Write them only while the meter is idle.
// Each sample is squared by a bit-serial shift-add into the running sum, so s_axis_tready
// drops after every accepted beat until the squaring and the block-end check are done.
// The sample that completes a block also runs a restoring divide by the block length,
// one quotient bit per cycle, and a digit-by-digit square root, one root bit per cycle;
// the result is registered when the meter leaves the done state, and the meter takes a
// new sample in the same cycle that the result becomes valid.
// The result sits in an output register, so the next block keeps running while the
// receiver stalls; only a second result waits for that register to drain, holding
// s_axis_tready low meanwhile.
// Reset clears the sum, the sample count and the output valid, and loads a block length
// of 256 and a port tag of 0.
module block_rms_meter_unit
  import rms_mtr_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire  [SAMPLE_W-1:0]  s_axis_tdata,   // [23:0] sample
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // [23:0] rms, [31:24] tag
  input  wire                  cfg_we_i,
  input  wire  [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  [CFG_W-1:0]     cfg_data_i
);

  rms_state_e state_q, state_d;

  logic [LEN_W-1:0]    blen_q;
  logic [TAG_W-1:0]    ptag_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [LEN_W-1:0]    count_q, count_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [SAMPLE_W-1:0] mg_q, mg_d;
  logic [SQ_W-1:0]     ad_q, ad_d;
  logic [LEN_W-1:0]    dr_q, dr_d;
  logic [WORK_W-1:0]   wk_q, wk_d;
  logic [SREM_W-1:0]   sr_q, sr_d;
  logic [ROOT_W-1:0]   rt_q, rt_d;
  logic                out_vld_q, out_vld_d;
  logic [RMS_W-1:0]    out_rms_q;
  logic [TAG_W-1:0]    out_tag_q;

  logic [LEN_W-1:0]    eff_len;
  logic                in_acc;
  logic                out_load;
  logic                last_step;
  logic                block_end;
  logic [SAMPLE_W-1:0] in_mag;
  logic [LEN_W:0]      div_trial;
  logic                div_ge;
  logic [SREM_W+1:0]   sq_rem;
  logic [SREM_W+1:0]   sq_trial;
  logic                sq_ge;

  always_comb begin
    if (blen_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (blen_q > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = blen_q;
    end
  end

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign in_mag    = s_axis_tdata[SAMPLE_W-1] ? (~s_axis_tdata + SAMPLE_W'(1)) : s_axis_tdata;
  assign block_end = (count_q >= eff_len);

  always_comb begin
    unique case (state_q)
      ST_SQUARE: last_step = (step_q == STEP_W'(SQ_STEPS - 1));
      ST_DIVIDE: last_step = (step_q == STEP_W'(DIV_STEPS - 1));
      ST_ROOT:   last_step = (step_q == STEP_W'(ROOT_STEPS - 1));
      default:   last_step = 1'b0;
    endcase
  end

  // Restoring divide: remainder with the next dividend bit against the block length.
  assign div_trial = {dr_q, wk_q[SUM_W-1]};
  assign div_ge    = (div_trial >= {1'b0, eff_len});

  // Square root: remainder with the next bit pair against 4*root+1.
  assign sq_rem   = {sr_q, wk_q[WORK_W-1 -: 2]};
  assign sq_trial = {2'b00, rt_q, 2'b01};
  assign sq_ge    = (sq_rem >= sq_trial);

  assign out_load = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_SQUARE;
      ST_SQUARE: if (last_step) state_d = ST_CHECK;
      ST_CHECK:  state_d = block_end ? ST_DIVIDE : ST_IDLE;
      ST_DIVIDE: if (last_step) state_d = ST_ROOT;
      ST_ROOT:   if (last_step) state_d = ST_DONE;
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    sum_d     = sum_q;
    count_d   = count_q;
    step_d    = last_step ? '0 : step_q + STEP_W'(1);
    mg_d      = mg_q;
    ad_d      = ad_q;
    dr_d      = dr_q;
    wk_d      = wk_q;
    sr_d      = sr_q;
    rt_d      = rt_q;
    out_vld_d = out_vld_q;
    s_axis_tready = (state_q == ST_IDLE);

    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_acc) begin
          mg_d    = in_mag;
          ad_d    = SQ_W'(in_mag);
          count_d = count_q + LEN_W'(1);
        end
      end
      ST_SQUARE: begin
        if (mg_q[0]) begin
          sum_d = sum_q + SUM_W'(ad_q);
        end
        mg_d = mg_q >> 1;
        ad_d = ad_q << 1;
      end
      ST_CHECK: begin
        step_d = '0;
        if (block_end) begin
          dr_d    = '0;
          wk_d    = {1'b0, sum_q};
          sum_d   = '0;
          count_d = '0;
        end
      end
      ST_DIVIDE: begin
        dr_d = div_ge ? LEN_W'(div_trial - {1'b0, eff_len}) : div_trial[LEN_W-1:0];
        wk_d = {1'b0, wk_q[SUM_W-2:0], div_ge};
        if (last_step) begin
          sr_d = '0;
          rt_d = '0;
        end
      end
      ST_ROOT: begin
        sr_d = sq_ge ? SREM_W'(sq_rem - sq_trial) : sq_rem[SREM_W-1:0];
        rt_d = {rt_q[ROOT_W-2:0], sq_ge};
        wk_d = {wk_q[WORK_W-3:0], 2'b00};
      end
      ST_DONE: begin
        step_d = '0;
        if (out_load) begin
          out_vld_d = 1'b1;
        end
      end
      default: begin
        step_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      blen_q    <= LEN_RESET;
      ptag_q    <= TAG_RESET;
      sum_q     <= '0;
      count_q   <= '0;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sum_q     <= sum_d;
      count_q   <= count_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BLOCK_LENGTH: blen_q <= cfg_data_i;
          REG_PORT_TAG:     ptag_q <= cfg_data_i[TAG_W-1:0];
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mg_q <= mg_d;
    ad_q <= ad_d;
    dr_q <= dr_d;
    wk_q <= wk_d;
    sr_q <= sr_d;
    rt_q <= rt_d;
    if (out_load) begin
      // Only the low bits of a root above full scale are reported.
      out_rms_q <= rt_q[RMS_W-1:0];
      out_tag_q <= ptag_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_tag_q, out_rms_q};

endmodule

`default_nettype wire

// ===== hw/rtl/rms_mtr_chk.sv =====
`default_nettype none

module rms_mtr_chk
  import rms_mtr_pkg::*;
(
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 s_axis_tvalid,
  input wire                 s_axis_tready,
  input wire [SAMPLE_W-1:0]  s_axis_tdata,
  input wire                 m_axis_tvalid,
  input wire                 m_axis_tready,
  input wire [31:0]          m_axis_tdata,
  input wire                 cfg_we_i,
  input wire [CFG_IDX_W-1:0] cfg_idx_i,
  input wire [CFG_W-1:0]     cfg_data_i
);

  // A stalled result beat keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Every accepted sample occupies the serial squarer.
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("sample taken while squarer busy");

  // A new result is only loaded while the input side is held off.
  a_result_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while meter idle");

endmodule

bind block_rms_meter_unit rms_mtr_chk u_rms_mtr_chk (.*);

`default_nettype wire
